// ===== rtl/core/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants for the cartridge bank mapper
// Command codes passed from the decode front to the execute back, the queue
// entry layout and the fixed decode and interrupt constants.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int LINE_W      = 10;
  localparam int PRG_W       = 8;
  localparam int CHR_W       = 9;
  localparam int PRG_COUNT_W = 9;
  localparam int CHR_COUNT_W = 10;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 1;

  localparam int QUEUE_DEPTH_DEF = 2;

  // Remainder unit: three dividend bits retired per cycle
  localparam int DIV_W     = 9;
  localparam int DIV_BITS  = 3;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  localparam logic [ADDR_W-1:0] DEC_MASK   = 16'hF800;
  localparam logic [ADDR_W-1:0] DEC_CHR0   = 16'h8800;
  localparam logic [ADDR_W-1:0] DEC_CHR1   = 16'h9800;
  localparam logic [ADDR_W-1:0] DEC_CHR2   = 16'hA800;
  localparam logic [ADDR_W-1:0] DEC_CHR3   = 16'hB800;
  localparam logic [ADDR_W-1:0] DEC_LATCH  = 16'hC800;
  localparam logic [ADDR_W-1:0] DEC_ENABLE = 16'hD800;
  localparam logic [ADDR_W-1:0] DEC_MIRROR = 16'hE800;
  localparam logic [ADDR_W-1:0] DEC_PRG    = 16'hF800;

  localparam int                ENABLE_BIT   = 4;
  localparam logic [DATA_W-1:0] IRQ_HIT      = 8'hF6;
  localparam logic [LINE_W-1:0] LAST_VISIBLE = 10'd239;

  localparam logic [CFG_IDX_W-1:0] REG_PRG_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHR_COUNT = 1'd1;

  localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RST = 9'd16;
  localparam logic [CHR_COUNT_W-1:0] CHR_COUNT_RST = 10'd128;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_CHR,
    CMD_LATCH,
    CMD_ENABLE,
    CMD_MIRROR,
    CMD_PRG,
    CMD_TICK,
    CMD_INIT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [1:0]        sel;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

// ===== rtl/core/cbm_front.sv =====
// ----------------------------------------------------------------------------
// cbm_front: request decode
// Classify each accepted request into a command for the execute side.
// ----------------------------------------------------------------------------
module cbm_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   req_type,
  input  logic [cbm_pkg::ADDR_W-1:0]   bus_address,
  input  logic [cbm_pkg::DATA_W-1:0]   bus_data,
  input  logic signed [cbm_pkg::LINE_W-1:0] scanline,
  input  logic                         rendering_on,
  input  logic                         q_full,
  output logic                         q_push,
  output cbm_pkg::cmd_t                q_entry
);
  import cbm_pkg::*;

  logic              visible;
  logic [ADDR_W-1:0] page;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign page     = bus_address & DEC_MASK;
  assign visible  = !scanline[LINE_W-1] && ($unsigned(scanline) <= LAST_VISIBLE);

  always_comb begin
    q_entry.kind = CMD_NOP;
    q_entry.sel  = page[13:12];
    q_entry.data = bus_data;
    case (req_type)
      REQ_WRITE: begin
        case (page)
          DEC_CHR0, DEC_CHR1, DEC_CHR2, DEC_CHR3: q_entry.kind = CMD_CHR;
          DEC_LATCH:  q_entry.kind = CMD_LATCH;
          DEC_ENABLE: q_entry.kind = CMD_ENABLE;
          DEC_MIRROR: q_entry.kind = CMD_MIRROR;
          DEC_PRG:    q_entry.kind = CMD_PRG;
          default:    q_entry.kind = CMD_NOP;
        endcase
      end
      REQ_TICK: begin
        // only a rendered visible line can move the counter
        if (visible && rendering_on) begin
          q_entry.kind = CMD_TICK;
        end
      end
      REQ_INIT: q_entry.kind = CMD_INIT;
      default:  q_entry.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== rtl/core/cbm_queue.sv =====
// ----------------------------------------------------------------------------
// cbm_queue: command queue
// Short first-in first-out buffer between decode and execute.
// ----------------------------------------------------------------------------
module cbm_queue #(
  parameter int DEPTH = cbm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cbm_pkg::cmd_t push_entry,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output cbm_pkg::cmd_t pop_entry
);
  import cbm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = (fill == CNT_W'(DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/cbm_back.sv =====
// ----------------------------------------------------------------------------
// cbm_back: command execute
// Hold the mapper state, run the page-count remainder and register results.
// ----------------------------------------------------------------------------
module cbm_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbm_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           q_valid,
  input  cbm_pkg::cmd_t                  q_entry,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cbm_pkg::PRG_W-1:0]      prg_page_first,
  output logic [cbm_pkg::PRG_W-1:0]      prg_page_second,
  output logic [cbm_pkg::CHR_W-1:0]      chr_quarter_0,
  output logic [cbm_pkg::CHR_W-1:0]      chr_quarter_1,
  output logic [cbm_pkg::CHR_W-1:0]      chr_quarter_2,
  output logic [cbm_pkg::CHR_W-1:0]      chr_quarter_3,
  output logic [1:0]                     mirror_mode,
  output logic                           irq_pulse
);
  import cbm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                 state, state_next;
  logic [PRG_COUNT_W-1:0] prg_count;
  logic [CHR_COUNT_W-1:0] chr_count;

  logic              irq_active, irq_active_next;
  logic [DATA_W-1:0] irq_count, irq_count_next;
  logic [DATA_W-1:0] irq_reload, irq_reload_next;
  logic [PRG_W-1:0]  prg0, prg0_next;
  logic [PRG_W-1:0]  prg1, prg1_next;
  logic [CHR_W-1:0]  chr_q [4];
  logic [CHR_W-1:0]  chr_q_next [4];
  logic [1:0]        mirror, mirror_next;
  logic              pulse_next;
  logic              commit;
  logic              out_free;

  logic [DIV_W-1:0]  rem, rem_next, rem_step;
  logic [DIV_W-1:0]  div_val, div_val_next;
  logic [1:0]        step, step_next;
  logic [DIV_W:0]    rem_inc;
  logic [DATA_W-1:0] dec;
  logic [DIV_W-1:0]  dbl;

  assign out_free = !out_valid || !out_stall;
  assign dbl      = {q_entry.data, 1'b0};
  assign rem_inc  = {1'b0, rem} + 1'b1;
  assign dec      = irq_count - 1'b1;

  // Restoring remainder: DIV_BITS dividend bits per cycle, MSB first
  always_comb begin
    logic [DIV_W:0] t;
    t = {1'b0, rem};
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {t[DIV_W-1:0], div_val[DIV_W-1-k]};
      if (t >= {1'b0, prg_count}) begin
        t = t - {1'b0, prg_count};
      end
    end
    rem_step = t[DIV_W-1:0];
  end

  always_comb begin
    state_next      = state;
    irq_active_next = irq_active;
    irq_count_next  = irq_count;
    irq_reload_next = irq_reload;
    prg0_next       = prg0;
    prg1_next       = prg1;
    chr_q_next      = chr_q;
    mirror_next     = mirror;
    pulse_next      = 1'b0;
    commit          = 1'b0;
    q_pop           = 1'b0;
    rem_next        = rem;
    div_val_next    = div_val;
    step_next       = step;
    case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop  = 1'b1;
          commit = 1'b1;
          case (q_entry.kind)
            CMD_CHR: chr_q_next[q_entry.sel] = dbl;
            CMD_LATCH: begin
              irq_count_next  = irq_reload;
              irq_reload_next = q_entry.data;
            end
            CMD_ENABLE: irq_active_next = q_entry.data[ENABLE_BIT];
            CMD_MIRROR: mirror_next = q_entry.data[1:0];
            CMD_PRG: begin
              if (prg_count != '0) begin
                commit       = 1'b0;
                state_next   = ST_DIV;
                rem_next     = '0;
                div_val_next = dbl;
                step_next    = '0;
              end else begin
                prg0_next = {q_entry.data[PRG_W-2:0], 1'b0};
                prg1_next = {q_entry.data[PRG_W-2:0], 1'b1};
              end
            end
            CMD_TICK: begin
              if (irq_active) begin
                if (dec == IRQ_HIT) begin
                  irq_count_next = irq_reload;
                  pulse_next     = 1'b1;
                end else begin
                  irq_count_next = dec;
                end
              end
            end
            CMD_INIT: begin
              prg0_next       = PRG_W'(0);
              prg1_next       = PRG_W'(1);
              chr_q_next[0]   = CHR_W'(0);
              chr_q_next[1]   = CHR_W'(2);
              chr_q_next[2]   = chr_count[CHR_W-1:0] - CHR_W'(4);
              chr_q_next[3]   = chr_count[CHR_W-1:0] - CHR_W'(2);
              irq_active_next = 1'b0;
              irq_count_next  = '0;
              irq_reload_next = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        rem_next     = rem_step;
        div_val_next = div_val << DIV_BITS;
        step_next    = step + 1'b1;
        if (step == 2'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          commit     = 1'b1;
          prg0_next  = rem[PRG_W-1:0];
          prg1_next  = (rem_inc == {1'b0, prg_count}) ? '0 : rem_inc[PRG_W-1:0];
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      prg_count  <= PRG_COUNT_RST;
      chr_count  <= CHR_COUNT_RST;
      irq_active <= 1'b0;
      irq_count  <= '0;
      irq_reload <= '0;
      prg0       <= PRG_W'(0);
      prg1       <= PRG_W'(1);
      chr_q[0]   <= CHR_W'(0);
      chr_q[1]   <= CHR_W'(2);
      chr_q[2]   <= CHR_W'(0);
      chr_q[3]   <= CHR_W'(0);
      mirror     <= '0;
    end else begin
      state      <= state_next;
      irq_active <= irq_active_next;
      irq_count  <= irq_count_next;
      irq_reload <= irq_reload_next;
      prg0       <= prg0_next;
      prg1       <= prg1_next;
      chr_q      <= chr_q_next;
      mirror     <= mirror_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PRG_COUNT: prg_count <= cfg_data[PRG_COUNT_W-1:0];
          REG_CHR_COUNT: chr_count <= cfg_data[CHR_COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rem     <= rem_next;
    div_val <= div_val_next;
    step    <= step_next;
    if (commit) begin
      prg_page_first  <= prg0_next;
      prg_page_second <= prg1_next;
      chr_quarter_0   <= chr_q_next[0];
      chr_quarter_1   <= chr_q_next[1];
      chr_quarter_2   <= chr_q_next[2];
      chr_quarter_3   <= chr_q_next[3];
      mirror_mode     <= mirror_next;
      irq_pulse       <= pulse_next;
    end
  end

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (prg_count != '0) && (rem < prg_count))
    else $error("remainder out of range during page reduction");

  a_pulse_reload: assert property (@(posedge clk) disable iff (rst)
    (commit && pulse_next) |=> (irq_count == irq_reload))
    else $error("counter not reloaded on interrupt");

  a_idle_counter: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && commit && q_entry.kind == CMD_TICK && !irq_active)
      |=> $stable(irq_count))
    else $error("counter moved while interrupt disabled");

endmodule

// ===== rtl/core/cartridge_bank_mapper_with_scanline_irq.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_scanline_irq: bank mapper with line interrupt
// Decode front, command queue and execute back of a switchable bank mapper.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per beat: a CPU
//   write (bus_address, bus_data), a scanline tick (scanline, rendering_on)
//   or a power-on init, selected by req_type.
//   Output channel (out_valid / out_stall) returns one beat per request: the
//   program pages, the four character quarters, the mirroring code and the
//   interrupt pulse, as they stand after that request.
//   Configuration: write prg_page_count (index 0) or chr_page_count (index 1)
//   through cfg_we / cfg_index / cfg_data, only while the block is idle.
// Timing:
//   Most requests pass through the queue slot and the result register, one
//   beat a cycle while out_stall is low. A program page write (0xF800) with
//   a nonzero page count runs the remainder unit, three bits per cycle, in
//   the execute side; the queue keeps accepting up to its depth meanwhile.
// Reset (rst, synchronous): empty the queue, drop any pending result and
//   restore the power-up bank state and the default page counts.
// Stall: while out_stall is high the result beat holds; the execute side
//   waits, the queue fills and then in_stall rises.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_scanline_irq #(
  parameter int QUEUE_DEPTH = cbm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbm_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         req_type,
  input  logic [cbm_pkg::ADDR_W-1:0]         bus_address,
  input  logic [cbm_pkg::DATA_W-1:0]         bus_data,
  input  logic signed [cbm_pkg::LINE_W-1:0]  scanline,
  input  logic                               rendering_on,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cbm_pkg::PRG_W-1:0]          prg_page_first,
  output logic [cbm_pkg::PRG_W-1:0]          prg_page_second,
  output logic [cbm_pkg::CHR_W-1:0]          chr_quarter_0,
  output logic [cbm_pkg::CHR_W-1:0]          chr_quarter_1,
  output logic [cbm_pkg::CHR_W-1:0]          chr_quarter_2,
  output logic [cbm_pkg::CHR_W-1:0]          chr_quarter_3,
  output logic [1:0]                         mirror_mode,
  output logic                               irq_pulse
);
  import cbm_pkg::*;

  // decode -> queue
  logic q_push;
  logic q_full;
  cmd_t q_in;

  // queue -> execute
  logic q_pop;
  logic q_valid;
  cmd_t q_out;

  // Classify each beat into a command; stall while the queue is full
  cbm_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .bus_address  (bus_address),
    .bus_data     (bus_data),
    .scanline     (scanline),
    .rendering_on (rendering_on),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_in)
  );

  // Hold commands so decode and execute can stall independently
  cbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_out)
  );

  // Apply commands in order to the bank state and register each result
  cbm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_valid         (q_valid),
    .q_entry         (q_out),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .prg_page_first  (prg_page_first),
    .prg_page_second (prg_page_second),
    .chr_quarter_0   (chr_quarter_0),
    .chr_quarter_1   (chr_quarter_1),
    .chr_quarter_2   (chr_quarter_2),
    .chr_quarter_3   (chr_quarter_3),
    .mirror_mode     (mirror_mode),
    .irq_pulse       (irq_pulse)
  );

endmodule
